// ===== rtl/bps_pkg.sv =====
package bps_pkg;

  localparam int unsigned PATTERN_WORDS = 7;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned START_W       = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUNDARY_LENGTH = 3'd0,
    CFG_PATTERN_WORD_0  = 3'd1,
    CFG_PATTERN_WORD_1  = 3'd2,
    CFG_PATTERN_WORD_2  = 3'd3,
    CFG_PATTERN_WORD_3  = 3'd4,
    CFG_PATTERN_WORD_4  = 3'd5,
    CFG_PATTERN_WORD_5  = 3'd6,
    CFG_PATTERN_WORD_6  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic               found;
    logic               full_res;
    logic [START_W-1:0] match_start;
    logic [LEN_W-1:0]   bytes_missing;
  } out_t;

endpackage

// ===== rtl/boundary_prefix_search.sv =====
// Boundary search over a byte stream, one byte per transaction. The block takes one byte every
// cycle unless a last byte is held back by a stalled result. The byte enters an input register,
// and a single shift-and stage then compares it against all boundary bytes at once and updates
// the partial-match vector. On the byte marked last, the same stage loads the result register,
// which drives the result output. A stalled result holds back the next last byte and, while it
// waits, the bytes behind it; bytes before it keep flowing. A full match reports the first one
// found; otherwise the earliest tail that is a prefix of the boundary is reported with the count
// of bytes still missing. Write the boundary length and pattern words only while the block is
// idle. Byte positions saturate at MAX_STRING_LEN-1; bytes from that position on are not scanned.
module boundary_prefix_search #(
  parameter int unsigned      MAX_BOUNDARY   = 56,
  parameter longint unsigned  MAX_STRING_LEN = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bps_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bps_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import bps_pkg::*;

  localparam int unsigned POS_W = (MAX_STRING_LEN > 2) ? $clog2(MAX_STRING_LEN) : 1;
  localparam int unsigned CW    = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_STRING_LEN - 1);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_BOUNDARY);

  logic [LEN_W-1:0]                          len_q;
  logic [PATTERN_WORDS-1:0][CFG_DATA_W-1:0]  pat_q;

  logic                    s1_valid_q;
  in_t                     s1_q;
  logic                    s1_adv;

  logic [MAX_BOUNDARY-1:0] live_q, live_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic                    full_seen_q, full_seen_d;
  logic [POS_W-1:0]        full_start_q, full_start_d;

  logic                    out_valid_q;
  out_t                    out_q, out_d;

  logic [LEN_W-1:0]        len_act;
  logic [LEN_W-1:0]        lenm1;
  logic [MAX_BOUNDARY-1:0] hits;
  logic [MAX_BOUNDARY-1:0] top_sel;
  logic [MAX_BOUNDARY-1:0] scan;
  logic                    at_limit;
  logic                    full_hit;
  logic                    tail_hit;
  logic [LEN_W-1:0]        tail_k;
  logic [CW-1:0]           sub_res;

  assign s1_adv     = s1_valid_q && (!s1_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
      pat_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BOUNDARY_LENGTH: len_q <= cfg_data_i[LEN_W-1:0];
        default:             pat_q[cfg_idx_i - CFG_PATTERN_WORD_0] <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    len_act = len_q;
    if (len_q == '0) begin
      len_act = LEN_W'(1);
    end else if (len_q > LEN_MAX) begin
      len_act = LEN_MAX;
    end
    lenm1    = len_act - LEN_W'(1);
    at_limit = (pos_q == POS_LIMIT);

    for (int k = 0; k < MAX_BOUNDARY; k++) begin
      hits[k]    = (LEN_W'(k) < len_act) && (pat_q[k/8][(k%8)*8 +: 8] == s1_q.data_byte);
      top_sel[k] = (LEN_W'(k) == lenm1);
    end

    live_d       = live_q;
    pos_d        = pos_q;
    full_seen_d  = full_seen_q;
    full_start_d = full_start_q;
    full_hit     = 1'b0;
    if (at_limit) begin
      live_d = '0;
    end else begin
      live_d   = MAX_BOUNDARY'({live_q, 1'b1}) & hits;
      full_hit = |(live_d & top_sel);
      if (!full_seen_q && full_hit && (CW'(pos_q) >= CW'(lenm1))) begin
        full_seen_d  = 1'b1;
        full_start_d = POS_W'(CW'(pos_q) - CW'(lenm1));
      end
      pos_d = pos_q + POS_W'(1);
    end

    scan     = live_d & ~top_sel;
    tail_hit = 1'b0;
    tail_k   = '0;
    for (int k = 0; k < MAX_BOUNDARY; k++) begin
      if (scan[k] && (LEN_W'(k) < lenm1)) begin
        tail_hit = 1'b1;
        tail_k   = LEN_W'(k);
      end
    end
    sub_res = CW'(pos_q) - CW'(tail_k);

    out_d = '0;
    if (full_seen_d) begin
      out_d.found       = 1'b1;
      out_d.full_res    = 1'b1;
      out_d.match_start = START_W'(full_start_d);
    end else if (!at_limit && (len_act > LEN_W'(1)) && tail_hit) begin
      out_d.found         = 1'b1;
      out_d.match_start   = START_W'(sub_res);
      out_d.bytes_missing = lenm1 - tail_k;
    end

    if (s1_q.last_byte) begin
      live_d       = '0;
      pos_d        = '0;
      full_seen_d  = 1'b0;
      full_start_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      live_q       <= '0;
      pos_q        <= '0;
      full_seen_q  <= 1'b0;
      full_start_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        live_q       <= live_d;
        pos_q        <= pos_d;
        full_seen_q  <= full_seen_d;
        full_start_q <= full_start_d;
      end
      if (s1_adv && s1_q.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_data_i;
    end
    if (s1_adv && s1_q.last_byte) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/bps_checker.sv =====
module bps_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bps_pkg::out_t out_data_o
);
  import bps_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result transaction changed while stalled");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      !out_data_o.full_res && out_data_o.match_start == '0 && out_data_o.bytes_missing == '0)
    else $error("empty result carries non-zero fields");

  a_full_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.full_res |-> out_data_o.found && out_data_o.bytes_missing == '0)
    else $error("full match reports missing bytes");

  a_tail_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found && !out_data_o.full_res |-> out_data_o.bytes_missing != '0)
    else $error("tail match reports no missing bytes");

endmodule

bind boundary_prefix_search bps_checker u_bps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  localparam int unsigned MAX_BND      = 56;
  localparam logic [15:0] POS_LIMIT    = 16'hFFFF;
  localparam int unsigned RANDOM_ITEMS = 1050;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  in_t                  in_data    = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  out_t                 out_data;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = CFG_BOUNDARY_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // boundary registers as the scanner sees them
  logic [5:0]  bnd_len_reg = 6'd1;
  logic [63:0] bnd_word [PATTERN_WORDS] = '{default: '0};

  // per-string scan state
  logic [55:0] scan_live = '0;
  logic [15:0] scan_pos  = '0;
  logic        full_hit  = 1'b0;
  logic [15:0] full_pos  = '0;

  out_t        report_q [$];
  logic [7:0]  str_q [$];
  logic [7:0]  stage_bytes [MAX_BND];

  int unsigned items_sent = 0;
  int unsigned errors     = 0;
  bit          src_burst  = 1'b0;
  bit          sink_burst = 1'b0;
  bit          long_hold  = 1'b0;

  boundary_prefix_search DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int unsigned eff_len(logic [5:0] l);
    if (l == 6'd0) return 1;
    if (l > MAX_BND) return MAX_BND;
    return int'(l);
  endfunction

  function automatic logic [7:0] pat_byte(int unsigned k);
    return bnd_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic void add_byte(logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endfunction

  function automatic void scan_byte(in_t item);
    int unsigned len;
    int unsigned k;
    logic [55:0] hits;
    logic [15:0] pos;
    out_t        rep;
    bit          hit;
    len  = eff_len(bnd_len_reg);
    pos  = scan_pos;
    hits = '0;
    if (pos >= POS_LIMIT) begin
      scan_live = '0;
    end else begin
      for (k = 0; k < len; k++) begin
        if (pat_byte(k) == item.data_byte) hits[k] = 1'b1;
      end
      scan_live = {scan_live[54:0], 1'b1} & hits;
      if (!full_hit && scan_live[len - 1] && pos >= len - 1) begin
        full_hit = 1'b1;
        full_pos = pos - 16'(len - 1);
      end
      scan_pos = pos + 16'd1;
    end
    if (item.last_byte) begin
      rep = '0;
      if (full_hit) begin
        rep.found       = 1'b1;
        rep.full_res    = 1'b1;
        rep.match_start = full_pos;
      end else if (pos < POS_LIMIT && len > 1) begin
        hit = 1'b0;
        for (k = len - 1; k > 0 && !hit; k--) begin
          if (scan_live[k - 1]) begin
            hit               = 1'b1;
            rep.found         = 1'b1;
            rep.match_start   = pos - 16'(k - 1);
            rep.bytes_missing = 6'(len - k);
          end
        end
      end
      report_q.insert(report_q.size(), rep);
      scan_live = '0;
      scan_pos  = '0;
      full_hit  = 1'b0;
      full_pos  = '0;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got %h", $time, out_data);
      end else begin
        want = report_q.pop_front();
        check_field("found", 16'(want.found), 16'(out_data.found));
        check_field("full_res", 16'(want.full_res), 16'(out_data.full_res));
        check_field("match_start", want.match_start, out_data.match_start);
        check_field("bytes_missing", 16'(want.bytes_missing), 16'(out_data.bytes_missing));
      end
    end
  end

  initial begin : sink_proc
    int unsigned hold;
    forever begin
      hold = sink_burst ? 0 : $urandom_range(0, 7);
      if (long_hold) begin
        hold      = 300;
        long_hold = 1'b0;
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input in_t item);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    scan_byte(item);
    items_sent++;
  endtask

  task automatic send_string();
    in_t item;
    while (str_q.size() != 0) begin
      item.data_byte = str_q.pop_front();
      item.last_byte = (str_q.size() == 0);
      send_byte(item);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == CFG_BOUNDARY_LENGTH) bnd_len_reg = value[5:0];
    else bnd_word[idx - CFG_PATTERN_WORD_0] = value;
  endtask

  task automatic load_boundary(input logic [63:0] len_word);
    int unsigned w;
    int unsigned b;
    logic [63:0] word;
    drain_results();
    write_reg(CFG_BOUNDARY_LENGTH, len_word);
    for (w = 0; w < PATTERN_WORDS; w++) begin
      for (b = 0; b < 8; b++) word[b * 8 +: 8] = stage_bytes[w * 8 + b];
      write_reg(cfg_idx_e'(CFG_PATTERN_WORD_0 + w), word);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_pattern(input bit narrow);
    int unsigned i;
    for (i = 0; i < MAX_BND; i++) begin
      if (narrow) stage_bytes[i] = $urandom_range(0, 1) ? 8'h5A : 8'hA5;
      else stage_bytes[i] = 8'($urandom());
    end
  endtask

  // mostly pieces of the boundary, with some noise in between
  task automatic build_string();
    int unsigned len;
    int unsigned chunks;
    int unsigned kind;
    int unsigned n;
    int unsigned j;
    len    = eff_len(bnd_len_reg);
    chunks = $urandom_range(1, 4);
    str_q.delete();
    repeat (chunks) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        for (j = 0; j < len; j++) add_byte(pat_byte(j));
      end else if (kind < 7) begin
        n = $urandom_range(1, len);
        for (j = 0; j < n; j++) add_byte(pat_byte(j));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 1)) add_byte(pat_byte($urandom_range(0, len - 1)));
          else add_byte(8'($urandom()));
        end
      end
    end
  endtask

  task automatic test_reset_config();
    str_q = '{8'h00};
    send_string();
    str_q = '{8'hFF, 8'h00};
    send_string();
    str_q = '{8'hFF};
    send_string();
    str_q = '{8'h00, 8'h00, 8'hFF};
    send_string();
  endtask

  task automatic test_directed();
    int unsigned i;
    for (i = 0; i < MAX_BND; i++) stage_bytes[i] = 8'h00;
    stage_bytes[0] = 8'h41;
    stage_bytes[1] = 8'h42;
    stage_bytes[2] = 8'h43;
    stage_bytes[3] = 8'h44;
    load_boundary(64'd4);
    str_q = '{8'h7A, 8'h41, 8'h42, 8'h43, 8'h44, 8'h7A};
    send_string();
    str_q = '{8'h41, 8'h42, 8'h43};
    send_string();
    str_q = '{8'h41, 8'h41, 8'h42};
    send_string();
    // zero length behaves as one
    stage_bytes[0] = 8'hFF;
    load_boundary(64'hFFFF_FFFF_FFFF_FFC0);
    str_q = '{8'h00, 8'hFF};
    send_string();
    // oversize length clamps to the maximum
    fill_pattern(1'b0);
    load_boundary(64'h0000_0000_0000_003F);
    str_q = '{stage_bytes[0], stage_bytes[1]};
    send_string();
  endtask

  task automatic test_backpressure();
    fill_pattern(1'b1);
    load_boundary(64'd2);
    src_burst = 1'b1;
    long_hold = 1'b1;
    repeat (60) begin
      build_string();
      send_string();
    end
    src_burst = 1'b0;
    drain_results();
  endtask

  task automatic test_random();
    int unsigned first;
    int unsigned len;
    int unsigned pick;
    int unsigned n;
    logic [63:0] len_word;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(1, 6);
      else if (pick < 8) len = $urandom_range(7, MAX_BND);
      else if (pick == 8) len = MAX_BND;
      else len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_BND + 1, 63);
      fill_pattern($urandom_range(0, 1));
      len_word      = {$urandom(), $urandom()};
      len_word[5:0] = len[5:0];
      load_boundary(len_word);
      src_burst  = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(2, 8);
      repeat (n) begin
        build_string();
        send_string();
      end
    end
    src_burst  = 1'b0;
    sink_burst = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned i;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_directed();
    test_backpressure();
    test_random();
    @(negedge clk);
    in_valid <= 1'b0;
    for (i = 0; i < 5000 && report_q.size() != 0; i++) @(posedge clk);
    if (report_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected transactions never arrived", $time, report_q.size());
    end
    repeat (10) @(posedge clk);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bps_pkg.sv
rtl/boundary_prefix_search.sv
rtl/bps_checker.sv
bench/testbench.sv
